@@ hdl/pscol_pkg.sv @@
// ----------------------------------------------------------------------------
// pscol_pkg: shared types and constants of the plane/sphere collision test
// Fixed-point widths, pair-kind codes, pipeline tag and result types.
// ----------------------------------------------------------------------------
package pscol_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int DIFF_W    = W + 1;
  localparam int PROD_W    = 2 * W;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int DQ_W      = DOT_W - FRAC_BITS;
  localparam int SAT_W     = DQ_W + 2;
  localparam int ROOT_W    = DIFF_W;
  localparam int REM_W     = SQ_W + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIVR_W    = ROOT_W + Q_W;
  localparam int LANES     = 3;

  localparam logic [1:0] ACT_PP = 2'd0;
  localparam logic [1:0] ACT_PS = 2'd1;
  localparam logic [1:0] ACT_SP = 2'd2;
  localparam logic [1:0] ACT_SS = 2'd3;

  typedef struct packed {
    logic                          is_ss;
    logic                          hit;
    logic [LANES-1:0][W-1:0]       dir;
    logic [W-1:0]                  depth;
    logic [DIFF_W-1:0]             r;
    logic [LANES-1:0][DIFF_W-1:0]  diff;
  } tag_t;

  typedef struct packed {
    logic         hit;
    logic [W-1:0] dir_x;
    logic [W-1:0] dir_y;
    logic [W-1:0] dir_z;
    logic [W-1:0] depth;
  } res_t;

  function automatic logic [W-1:0] sat_w(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({{(SAT_W-W+1){1'b0}}, {(W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[W-1:0];
    end else if (v < lo) begin
      return lo[W-1:0];
    end
    return v[W-1:0];
  endfunction

endpackage

@@ hdl/pscol_if.sv @@
// ----------------------------------------------------------------------------
// pscol_req_if / pscol_rsp_if: request and result channels
// Valid/ready channels carrying one shape pair and one collision result.
// ----------------------------------------------------------------------------
interface pscol_req_if import pscol_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] a_w;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;
  logic signed [W-1:0] b_w;
  modport source(output valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                 input ready);
  modport sink(input valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
               output ready);
endinterface

interface pscol_rsp_if import pscol_pkg::*;;
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;
  logic signed [W-1:0] depth;
  modport source(output valid, hit, dir_x, dir_y, dir_z, depth, input ready);
  modport sink(input valid, hit, dir_x, dir_y, dir_z, depth, output ready);
endinterface

@@ hdl/pscol_sqrt.sv @@
// ----------------------------------------------------------------------------
// pscol_sqrt: pipelined integer square root
// One root bit per stage, restoring digit-by-digit; tag travels alongside.
// ----------------------------------------------------------------------------
module pscol_sqrt import pscol_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  tag_t              tag_in,
  input  logic [SQ_W-1:0]   rad_in,
  output logic              v_out,
  output tag_t              tag_out,
  output logic [ROOT_W-1:0] root_out
);

  logic              v_r    [ROOT_W];
  tag_t              tag_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stg
    localparam int B = ROOT_W - 1 - s;
    logic              v_i;
    tag_t              tag_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [REM_W-1:0]  trial;

    if (s == 0) begin : g_first
      assign v_i    = v_in;
      assign tag_i  = tag_in;
      assign rem_i  = REM_W'(rad_in);
      assign root_i = '0;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign tag_i  = tag_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
    end

    assign trial = (REM_W'(root_i) << (B + 1)) | (REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= tag_i;
        if (rem_i >= trial) begin
          rem_r[s]  <= rem_i - trial;
          root_r[s] <= root_i | (ROOT_W'(1) << B);
        end else begin
          rem_r[s]  <= rem_i;
          root_r[s] <= root_i;
        end
      end
    end
  end

  assign v_out    = v_r[ROOT_W-1];
  assign tag_out  = tag_r[ROOT_W-1];
  assign root_out = root_r[ROOT_W-1];

endmodule

@@ hdl/pscol_div.sv @@
// ----------------------------------------------------------------------------
// pscol_div: pipelined three-lane divider
// Divides each center-difference magnitude, scaled to Q format, by the root.
// One quotient bit per stage and lane.
// ----------------------------------------------------------------------------
module pscol_div import pscol_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  tag_t              tag_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic              v_out,
  output tag_t              tag_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [Q_W-1:0]    q_out [LANES]
);

  logic              v_r    [Q_W];
  tag_t              tag_r  [Q_W];
  logic [ROOT_W-1:0] root_r [Q_W];
  logic [DIVR_W-1:0] rem_r  [Q_W][LANES];
  logic [Q_W-1:0]    q_r    [Q_W][LANES];

  for (genvar s = 0; s < Q_W; s++) begin : g_stg
    localparam int K = Q_W - 1 - s;
    logic              v_i;
    tag_t              tag_i;
    logic [ROOT_W-1:0] root_i;
    logic [DIVR_W-1:0] rem_i [LANES];
    logic [Q_W-1:0]    q_i   [LANES];
    logic [DIVR_W-1:0] trial;

    if (s == 0) begin : g_first
      assign v_i    = v_in;
      assign tag_i  = tag_in;
      assign root_i = root_in;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [DIFF_W-1:0] mag;
        assign mag      = tag_in.diff[l][DIFF_W-1] ? (DIFF_W'(0) - tag_in.diff[l])
                                                   : tag_in.diff[l];
        assign rem_i[l] = DIVR_W'(mag) << FRAC_BITS;
        assign q_i[l]   = '0;
      end
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign tag_i  = tag_r[s-1];
      assign root_i = root_r[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_i[l] = rem_r[s-1][l];
        assign q_i[l]   = q_r[s-1][l];
      end
    end

    assign trial = DIVR_W'(root_i) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s]  <= tag_i;
        root_r[s] <= root_i;
        for (int l = 0; l < LANES; l++) begin
          if (rem_i[l] >= trial) begin
            rem_r[s][l] <= rem_i[l] - trial;
            q_r[s][l]   <= q_i[l] | (Q_W'(1) << K);
          end else begin
            rem_r[s][l] <= rem_i[l];
            q_r[s][l]   <= q_i[l];
          end
        end
      end
    end
  end

  assign v_out    = v_r[Q_W-1];
  assign tag_out  = tag_r[Q_W-1];
  assign root_out = root_r[Q_W-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign q_out[l] = q_r[Q_W-1][l];
  end

endmodule

@@ hdl/plane_sphere_collision_test_core.sv @@
// ----------------------------------------------------------------------------
// plane_sphere_collision_test_core: narrow-phase pair collision test
// Plane-plane, plane-sphere, sphere-plane and sphere-sphere tests in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one shape pair per request (action, a_*, b_*); out_rsp
//   returns one result per request (hit, dir_*, depth), in request order.
//   From acceptance to out_rsp.valid a request passes three front stages
//   (products, sums, plane tests), 33 square-root stages (one root bit each)
//   and 17 divider stages (one quotient bit each), then the output register.
//   Throughput: one request per cycle unless stalled; fully pipelined.
//   in_req.ready comes from a register: it drops only while the skid entry
//   behind the output register is occupied, so a stalled receiver holds the
//   pipeline after at most one extra result; nothing is lost or repeated.
//   Reset clears all valid bits; in_req.ready is high once the skid entry is clear.
// ----------------------------------------------------------------------------
module plane_sphere_collision_test_core import pscol_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pscol_req_if.sink   in_req,
  pscol_rsp_if.source out_rsp
);

  logic en;

  logic                       v1_r;
  logic [1:0]                 act1_r;
  logic signed [W-1:0]        a1_r [4];
  logic signed [W-1:0]        b1_r [4];
  logic signed [PROD_W-1:0]   p1_r [LANES];
  logic signed [SQ_W-1:0]     sq1_r [LANES];
  logic signed [DIFF_W-1:0]   dif1_r [LANES];
  logic signed [DIFF_W-1:0]   r1_r;
  logic signed [SQ_W-1:0]     rr1_r;

  logic signed [W-1:0]        a_c [4];
  logic signed [W-1:0]        b_c [4];
  logic signed [PROD_W-1:0]   p_c [LANES];
  logic signed [SQ_W-1:0]     sq_c [LANES];
  logic signed [DIFF_W-1:0]   dif_c [LANES];
  logic signed [DIFF_W-1:0]   r_c;

  logic                       v2_r;
  logic [1:0]                 act2_r;
  logic signed [W-1:0]        a2_r [4];
  logic signed [W-1:0]        b2_r [4];
  logic signed [DIFF_W-1:0]   dif2_r [LANES];
  logic signed [DIFF_W-1:0]   r2_r;
  logic signed [DOT_W-1:0]    dot2_r;
  logic [SQ_W-1:0]            s2_r;
  logic [SQ_W-1:0]            rr2_r;

  logic                       v3_r;
  tag_t                       tag3_r;
  logic [SQ_W-1:0]            rad3_r;
  tag_t                       tag_c;
  logic signed [DQ_W-1:0]     dq_c;
  logic signed [SAT_W-1:0]    dps_c;
  logic signed [SAT_W-1:0]    dsp_c;

  localparam logic signed [DQ_W-1:0] ONE_DQ = DQ_W'(1) << FRAC_BITS;

  logic              sq_v;
  tag_t              sq_tag;
  logic [ROOT_W-1:0] sq_root;

  logic              dv_v;
  tag_t              dv_tag;
  logic [ROOT_W-1:0] dv_root;
  logic [Q_W-1:0]    dv_q [LANES];

  res_t                pres;
  logic [W-1:0]        dir_c [LANES];
  res_t                out_r;
  logic                out_v_r;
  res_t                skid_r;
  logic                skid_v_r;
  logic                take;

  assign en           = !skid_v_r;
  assign in_req.ready = en;

  assign a_c[0] = in_req.a_x;
  assign a_c[1] = in_req.a_y;
  assign a_c[2] = in_req.a_z;
  assign a_c[3] = in_req.a_w;
  assign b_c[0] = in_req.b_x;
  assign b_c[1] = in_req.b_y;
  assign b_c[2] = in_req.b_z;
  assign b_c[3] = in_req.b_w;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p_c[l]   = a_c[l] * b_c[l];
      dif_c[l] = $signed({a_c[l][W-1], a_c[l]}) - $signed({b_c[l][W-1], b_c[l]});
      sq_c[l]  = dif_c[l] * dif_c[l];
    end
    r_c = $signed({a_c[3][W-1], a_c[3]}) + $signed({b_c[3][W-1], b_c[3]});
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1_r <= in_req.action;
      a1_r   <= a_c;
      b1_r   <= b_c;
      p1_r   <= p_c;
      sq1_r  <= sq_c;
      dif1_r <= dif_c;
      r1_r   <= r_c;
      rr1_r  <= r_c * r_c;
    end
  end

  // stage 2: sums
  always_ff @(posedge clk) begin
    if (en) begin
      act2_r <= act1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      dif2_r <= dif1_r;
      r2_r   <= r1_r;
      dot2_r <= DOT_W'(p1_r[0]) + DOT_W'(p1_r[1]) + DOT_W'(p1_r[2]);
      s2_r   <= $unsigned(sq1_r[0]) + $unsigned(sq1_r[1]) + $unsigned(sq1_r[2]);
      rr2_r  <= $unsigned(rr1_r);
    end
  end

  // stage 3: plane tests
  always_comb begin
    dq_c  = $signed(dot2_r[DOT_W-1:FRAC_BITS]);
    dps_c = SAT_W'(dq_c) + SAT_W'(a2_r[3]) - SAT_W'(b2_r[3]);
    dsp_c = SAT_W'(dq_c) + SAT_W'(b2_r[3]) - SAT_W'(a2_r[3]);
    tag_c = '0;
    tag_c.r = r2_r;
    for (int l = 0; l < LANES; l++) begin
      tag_c.diff[l] = dif2_r[l];
    end
    case (act2_r)
      ACT_PP: begin
        if ((dq_c < ONE_DQ) && (dq_c > -ONE_DQ)) begin
          tag_c.hit = 1'b1;
          for (int l = 0; l < LANES; l++) tag_c.dir[l] = a2_r[l];
        end
      end
      ACT_PS: begin
        if (dps_c <= 0) begin
          tag_c.hit   = 1'b1;
          tag_c.depth = sat_w(-dps_c);
          for (int l = 0; l < LANES; l++) tag_c.dir[l] = a2_r[l];
        end
      end
      ACT_SP: begin
        if (dsp_c <= 0) begin
          tag_c.hit   = 1'b1;
          tag_c.depth = sat_w(-dsp_c);
          for (int l = 0; l < LANES; l++) tag_c.dir[l] = sat_w(-SAT_W'(b2_r[l]));
        end
      end
      default: begin
        tag_c.is_ss = 1'b1;
        tag_c.hit   = (s2_r <= rr2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r <= tag_c;
      rad3_r <= s2_r;
    end
  end

  pscol_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v3_r),
    .tag_in   (tag3_r),
    .rad_in   (rad3_r),
    .v_out    (sq_v),
    .tag_out  (sq_tag),
    .root_out (sq_root)
  );

  pscol_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (sq_v),
    .tag_in   (sq_tag),
    .root_in  (sq_root),
    .v_out    (dv_v),
    .tag_out  (dv_tag),
    .root_out (dv_root),
    .q_out    (dv_q)
  );

  // final result
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dir_c[l] = dv_tag.dir[l];
    end
    pres       = '0;
    pres.depth = dv_tag.depth;
    if (dv_tag.is_ss) begin
      for (int l = 0; l < LANES; l++) begin
        if (dv_root == '0) begin
          dir_c[l] = '0;
        end else if (dv_tag.diff[l][DIFF_W-1]) begin
          dir_c[l] = W'(dv_q[l]);
        end else begin
          dir_c[l] = W'(0) - W'(dv_q[l]);
        end
      end
      pres.depth = sat_w(SAT_W'($signed(dv_tag.r))
                         - $signed({{(SAT_W-ROOT_W){1'b0}}, dv_root}));
    end
    pres.hit   = dv_tag.hit;
    pres.dir_x = dir_c[0];
    pres.dir_y = dir_c[1];
    pres.dir_z = dir_c[2];
    if (!dv_tag.hit) begin
      pres = '0;
    end
  end

  // output register and skid entry
  assign take = !out_v_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= dv_v;
      end
    end else if (en && dv_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : pres;
    end else if (en && dv_v) begin
      skid_r <= pres;
    end
  end

  assign out_rsp.valid = out_v_r;
  assign out_rsp.hit   = out_r.hit;
  assign out_rsp.dir_x = out_r.dir_x;
  assign out_rsp.dir_y = out_r.dir_y;
  assign out_rsp.dir_z = out_r.dir_z;
  assign out_rsp.depth = out_r.depth;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry occupied while output register empty");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_rsp.ready |=> skid_v_r && $stable(skid_r))
    else $error("skid entry changed under stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.hit |-> out_r.dir_x == '0 && out_r.dir_y == '0
                              && out_r.dir_z == '0 && out_r.depth == '0)
    else $error("miss result with nonzero fields");
`endif

endmodule
